### hdl/dma_region_allow_table_top_assert.svh
// Assertion macros for the DMA region allow table
`ifndef DMA_REGION_ALLOW_TABLE_TOP_ASSERT_SVH
`define DMA_REGION_ALLOW_TABLE_TOP_ASSERT_SVH

// implication checked on every clock, quiet during reset
`define DMARAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define DMARAT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hdl/dmarat_pkg.sv
// Types and constants shared by the DMA region allow table
package dmarat_pkg;

  localparam int unsigned PAGE_SHIFT = 12;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2
  } func_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_NO_FREE    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  localparam logic REG_VERSION_SELECT = 1'b0;
  localparam logic REG_PROTECTED_MASK = 1'b1;

  localparam logic [30:0] LIMIT_V2 = 31'h00FF_FFFF;
  localparam logic [30:0] LIMIT_V3 = 31'h3FFF_FFFF;

  localparam int unsigned MASK_BITS = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [43:0] region_addr;
    logic [42:0] region_bytes;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [3:0] entry_used;
  } out_item_t;

  // request as every cell sees it while the token walks
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] page;
    logic [30:0] pages;
    logic        aligned;
    logic        too_big;
  } req_t;

  // token handed from cell to cell
  typedef struct packed {
    logic       live;
    logic       done;
    logic [2:0] status;
    logic [3:0] idx;
  } tok_t;

endpackage

### hdl/dma_region_allow_table_top.sv
// Top level of the DMA region allow table: config, request launch, cell chain, result
//
//   channel | signals                     | transfer when
//   --------+-----------------------------+-------------------------
//   in      | in_valid in_ready in_item   | in_valid && in_ready
//   out     | out_valid out_ready out_item| out_valid && out_ready
//   cfg     | cfg_we cfg_index cfg_data   | cfg_we
//
// A request token walks the entry chain one cell per cycle; the result is registered
// from the token that leaves the chain, and one request is in hand at a time,
// so a new request is taken only after the last result has transferred.
// in_ready is high only with the chain empty and no result pending.
// Reset clears all valid marks, both registers and the handshake state.
// A stalled output holds its result and keeps in_ready low until its transfer.
module dma_region_allow_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dmarat_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dmarat_pkg::out_item_t  out_item,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data
);
  import dmarat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t                  state;
  logic                    version_select;
  logic [MASK_BITS-1:0]    protected_mask;
  req_t                    req;
  req_t                    req_next;
  logic                    launch;
  tok_t                    tok [ENTRIES+1];
  logic [ENTRIES-1:0]      prot;
  out_item_t               result;

  assign in_ready = (state == S_IDLE);

  assign tok[0] = '{live: launch, done: 1'b0, status: ST_OK, idx: 4'd0};

  always_comb begin
    req_next.func    = in_item.func;
    req_next.page    = in_item.region_addr[43:PAGE_SHIFT];
    req_next.pages   = in_item.region_bytes[42:PAGE_SHIFT];
    req_next.aligned = (in_item.region_bytes[PAGE_SHIFT-1:0] == '0) &&
                       (in_item.region_addr[PAGE_SHIFT-1:0] == '0);
    req_next.too_big = version_select ? (req_next.pages > LIMIT_V3)
                                      : (req_next.pages > LIMIT_V2);
  end

  // entries beyond the mask width are never protected
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i < MASK_BITS) begin : g_prot
      assign prot[i] = protected_mask[i];
    end else begin : g_open
      assign prot[i] = 1'b0;
    end
    dmarat_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .req     (req),
      .prot    (prot[i]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // result from the token leaving the chain, with a default status when no cell decided the outcome
  always_comb begin
    result.entry_used = 4'd0;
    if (tok[ENTRIES].done) begin
      result.status     = tok[ENTRIES].status;
      result.entry_used = tok[ENTRIES].idx;
    end else begin
      case (req.func)
        FN_ADD:   result.status = ST_NO_FREE;
        FN_CLEAR: result.status = ST_OK;
        default:  result.status = ST_NOT_FOUND;
      endcase
    end
    result.ok = (result.status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_select <= 1'b0;
      protected_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERSION_SELECT: version_select <= cfg_data[0];
        REG_PROTECTED_MASK: protected_mask <= cfg_data;
        default:            version_select <= version_select;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      launch <= (state == S_IDLE) && in_valid;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= req_next;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok[ENTRIES].live) begin
            out_item  <= result;
            out_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/dmarat_cell.sv
// One table entry and its stage of the request token chain
module dmarat_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  dmarat_pkg::req_t  req,
  input  logic              prot,
  input  dmarat_pkg::tok_t  tok_in,
  output dmarat_pkg::tok_t  tok_out
);
  import dmarat_pkg::*;

  logic        valid;
  logic        valid_next;
  logic [31:0] page;
  logic [29:0] pages;
  logic        write;
  tok_t        tok_next;

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    write      = 1'b0;
    if (tok_in.live && !prot) begin
      case (req.func)
        FN_ADD: begin
          // first free unprotected entry decides the outcome
          if (!valid && !tok_in.done) begin
            tok_next.done = 1'b1;
            if (!req.aligned) begin
              tok_next.status = ST_MISALIGNED;
            end else if (req.too_big) begin
              tok_next.status = ST_TOO_LARGE;
            end else begin
              tok_next.status = ST_OK;
              tok_next.idx    = 4'(INDEX);
              valid_next      = 1'b1;
              write           = 1'b1;
            end
          end
        end
        FN_REMOVE: begin
          if (valid && !tok_in.done && req.aligned && page == req.page &&
              {1'b0, pages} == req.pages) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            tok_next.idx    = 4'(INDEX);
            valid_next      = 1'b0;
          end
        end
        FN_CLEAR: begin
          valid_next = 1'b0;
        end
        default: begin
          valid_next = valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      page  <= req.page;
      pages <= req.pages[29:0];
    end
  end

endmodule

### hdl/dmarat_checker.sv
// Port-level checks for the DMA region allow table, bound to the top level
`include "dma_region_allow_table_top_assert.svh"

module dmarat_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input dmarat_pkg::out_item_t  out_item
);
  import dmarat_pkg::*;

  // one request in hand: no new transfer while a result waits
  `DMARAT_NEVER(a_busy_excl, in_ready && out_valid, "input ready with result pending")
  `DMARAT_ASSERT(a_one_req, (in_valid && in_ready) |=> !in_ready, "second request taken")
  `DMARAT_ASSERT(a_ok_code, out_valid |-> (out_item.ok == (out_item.status == ST_OK)),
    "ok disagrees with status")
  `DMARAT_ASSERT(a_fail_idx, (out_valid && !out_item.ok) |-> (out_item.entry_used == 4'd0),
    "failed transfer names an entry")
  `DMARAT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)),
    "stalled result changed")

endmodule

bind dma_region_allow_table_top dmarat_checker u_dmarat_checker (.*);

### tb/tb_dma_region_allow_table_top.sv
// Self-checking bench for the DMA region allow table: directed plan, then random traffic
module tb_dma_region_allow_table_top;
  import dmarat_pkg::*;

  localparam int          ENTRIES   = 16;
  localparam int          PHASES    = 8;
  localparam int unsigned QUIET_MAX = 2000;
  localparam logic [1:0]  FN_UNUSED = 2'd3;

  typedef struct packed {
    logic        is_cfg;
    logic        reg_sel;
    logic [15:0] reg_val;
    in_item_t    req;
    logic        typed;
    out_item_t   want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  // shadow of the region table and registers
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_page  [ENTRIES];
  logic [29:0] tbl_pages [ENTRIES];
  logic        ver_sel;
  logic [15:0] prot_mask;

  out_item_t   pending [$];
  plan_row_t   plan [$];
  out_item_t   head;
  bit          calm;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  int unsigned hold_draw;
  logic        vbit;
  logic [15:0] mask_pick;

  dma_region_allow_table_top #(.ENTRIES(ENTRIES)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t apply_request(input in_item_t r);
    out_item_t   res;
    logic [31:0] pg;
    logic [30:0] npg;
    logic [30:0] cap;
    logic        aligned;
    int          hit;
    pg             = r.region_addr[43:12];
    npg            = r.region_bytes[42:12];
    cap            = ver_sel ? LIMIT_V3 : LIMIT_V2;
    aligned        = (r.region_addr[11:0] == 12'h000) && (r.region_bytes[11:0] == 12'h000);
    hit            = -1;
    res.ok         = 1'b0;
    res.status     = ST_NOT_FOUND;
    res.entry_used = 4'd0;
    case (r.func)
      FN_ADD: begin
        // walk downwards so the lowest candidate wins
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!prot_mask[i] && !tbl_valid[i]) hit = i;
        if (hit < 0) begin
          res.status = ST_NO_FREE;
        end else if (!aligned) begin
          res.status = ST_MISALIGNED;
        end else if (npg > cap) begin
          res.status = ST_TOO_LARGE;
        end else begin
          tbl_valid[hit] = 1'b1;
          tbl_page[hit]  = pg;
          tbl_pages[hit] = npg[29:0];
          res.ok         = 1'b1;
          res.status     = ST_OK;
          res.entry_used = hit[3:0];
        end
      end
      FN_REMOVE: begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (aligned && !prot_mask[i] && tbl_valid[i] && tbl_page[i] == pg &&
              {1'b0, tbl_pages[i]} == npg) hit = i;
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          res.ok         = 1'b1;
          res.status     = ST_OK;
          res.entry_used = hit[3:0];
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++)
          if (!prot_mask[i]) tbl_valid[i] = 1'b0;
        res.ok     = 1'b1;
        res.status = ST_OK;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic plan_row_t req_row(input logic [1:0] fn, input logic [43:0] addr,
                                        input logic [42:0] bytes, input logic typed,
                                        input logic ok, input logic [2:0] st,
                                        input logic [3:0] idx);
    plan_row_t row;
    row                   = '0;
    row.req.func          = fn;
    row.req.region_addr   = addr;
    row.req.region_bytes  = bytes;
    row.typed             = typed;
    row.want.ok           = ok;
    row.want.status       = st;
    row.want.entry_used   = idx;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic sel, input logic [15:0] val);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // mostly well-formed adds and removes of live regions, plus some noise
  function automatic in_item_t pick_request();
    in_item_t    r;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [31:0] pg;
    logic [30:0] npg;
    logic [30:0] cap;
    int unsigned roll;
    int unsigned slot;
    w0   = {$urandom(), $urandom()};
    w1   = {$urandom(), $urandom()};
    cap  = ver_sel ? LIMIT_V3 : LIMIT_V2;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, ENTRIES - 1);
    pg   = ($urandom_range(0, 3) == 0) ? w0[31:0] : {29'd0, w1[50:48]};
    case ($urandom_range(0, 7))
      0:       npg = cap;
      1:       npg = cap - 31'd1;
      2:       npg = w1[30:0] & cap;
      default: npg = {28'd0, w1[34:32]};
    endcase
    r.func         = FN_ADD;
    r.region_addr  = {pg, 12'h000};
    r.region_bytes = {npg, 12'h000};
    if (roll < 40) begin
      r.func = FN_ADD;
    end else if (roll < 70) begin
      r.func = FN_REMOVE;
      if (tbl_valid[slot]) begin
        r.region_addr  = {tbl_page[slot], 12'h000};
        r.region_bytes = {1'b0, tbl_pages[slot], 12'h000};
      end
    end else if (roll < 76) begin
      r.func = FN_REMOVE;
    end else if (roll < 80) begin
      r.func = FN_CLEAR;
    end else if (roll < 83) begin
      r.func = FN_UNUSED;
    end else if (roll < 88) begin
      r.func = w0[40] ? FN_REMOVE : FN_ADD;
      if (w0[41])
        r.region_addr[11:0] = (w1[11:0] == 12'h000) ? 12'h800 : w1[11:0];
      else
        r.region_bytes[11:0] = (w1[11:0] == 12'h000) ? 12'h001 : w1[11:0];
    end else if (roll < 93) begin
      npg            = w0[42] ? cap + 31'd1 : {1'b1, w1[29:0]};
      r.region_bytes = {npg, 12'h000};
    end else begin
      r.func         = w0[63:62];
      r.region_addr  = w0[43:0];
      r.region_bytes = w1[42:0];
    end
    return r;
  endfunction

  task automatic push_request(input in_item_t r, input logic typed, input out_item_t want);
    out_item_t   guess;
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (!in_ready);
    guess = apply_request(r);
    pending.push_back(typed ? want : guess);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_VERSION_SELECT) ver_sel = val[0];
    else prot_mask = val;
  endtask

  // result side: hold off out_ready for a random draw once a result shows
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && out_ready) begin
      hold_draw = calm ? 0 : $urandom_range(0, 12);
      out_ready <= (hold_draw == 0);
      hold_left <= hold_draw;
    end else if (out_valid && !out_ready) begin
      if (hold_left == 0) out_ready <= 1'b1;
      else hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending.size() == 0) begin
          $display("%0t: result with nothing expected: ok %0d status %0d entry %0d",
                   $time, out_item.ok, out_item.status, out_item.entry_used);
          fail_count++;
        end else begin
          head = pending.pop_front();
          if (out_item.ok !== head.ok) begin
            $display("%0t: ok expected %0d actual %0d", $time, head.ok, out_item.ok);
            fail_count++;
          end
          if (out_item.status !== head.status) begin
            $display("%0t: status expected %0d actual %0d", $time, head.status,
                     out_item.status);
            fail_count++;
          end
          if (out_item.entry_used !== head.entry_used) begin
            $display("%0t: entry_used expected %0d actual %0d", $time, head.entry_used,
                     out_item.entry_used);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    ver_sel   = 1'b0;
    prot_mask = '0;

    plan.push_back(req_row(FN_REMOVE, 44'h0, 43'h1000, 1, 0, ST_NOT_FOUND, 4'd0));
    // zero length is a legal region
    plan.push_back(req_row(FN_ADD, 44'h0, 43'h0, 1, 1, ST_OK, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h2000, 43'h1001, 1, 0, ST_MISALIGNED, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h2800, 43'h1000, 1, 0, ST_MISALIGNED, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h3000, 43'h010_0000_0000, 1, 0, ST_TOO_LARGE, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h3000, 43'h00F_FFFF_F000, 1, 1, ST_OK, 4'd1));
    plan.push_back(req_row(FN_ADD, 44'hFFF_FFFF_F000, 43'h1000, 1, 1, ST_OK, 4'd2));
    plan.push_back(req_row(FN_ADD, 44'hFFF_FFFF_FFFF, 43'h7FF_FFFF_FFFF, 1, 0,
                           ST_MISALIGNED, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h0, 43'h7FF_FFFF_F000, 1, 0, ST_TOO_LARGE, 4'd0));
    plan.push_back(req_row(FN_REMOVE, 44'h0, 43'h0, 1, 1, ST_OK, 4'd0));
    // misaligned remove never matches
    plan.push_back(req_row(FN_REMOVE, 44'h3001, 43'h00F_FFFF_F000, 1, 0, ST_NOT_FOUND,
                           4'd0));
    plan.push_back(req_row(FN_REMOVE, 44'h3000, 43'h00F_FFFF_E000, 0, 0, ST_OK, 4'd0));
    plan.push_back(req_row(FN_REMOVE, 44'hFFF_FFFF_F000, 43'h1000, 1, 1, ST_OK, 4'd2));
    plan.push_back(req_row(FN_UNUSED, 44'hFFF_FFFF_FFFF, 43'h7FF_FFFF_FFFF, 1, 0,
                           ST_NOT_FOUND, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h4000, 43'h2000, 0, 0, ST_OK, 4'd0));
    plan.push_back(req_row(FN_CLEAR, 44'h0, 43'h0, 1, 1, ST_OK, 4'd0));
    plan.push_back(cfg_row(REG_VERSION_SELECT, 16'h0001));
    plan.push_back(req_row(FN_ADD, 44'h5000, 43'h3FF_FFFF_F000, 1, 1, ST_OK, 4'd0));
    plan.push_back(req_row(FN_ADD, 44'h5000, 43'h400_0000_0000, 1, 0, ST_TOO_LARGE, 4'd0));
    plan.push_back(cfg_row(REG_PROTECTED_MASK, 16'h0001));
    plan.push_back(req_row(FN_REMOVE, 44'h5000, 43'h3FF_FFFF_F000, 1, 0, ST_NOT_FOUND,
                           4'd0));
    plan.push_back(req_row(FN_ADD, 44'h6000, 43'h1000, 0, 0, ST_OK, 4'd0));
    // everything protected: no free entry, alignment not looked at
    plan.push_back(cfg_row(REG_PROTECTED_MASK, 16'hFFFF));
    plan.push_back(req_row(FN_ADD, 44'h123, 43'h1, 1, 0, ST_NO_FREE, 4'd0));
    plan.push_back(req_row(FN_CLEAR, 44'h0, 43'h0, 1, 1, ST_OK, 4'd0));
    plan.push_back(cfg_row(REG_PROTECTED_MASK, 16'h0000));
    plan.push_back(req_row(FN_REMOVE, 44'h5000, 43'h3FF_FFFF_F000, 1, 1, ST_OK, 4'd0));
    plan.push_back(req_row(FN_REMOVE, 44'h6000, 43'h1000, 1, 1, ST_OK, 4'd1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].reg_sel, plan[k].reg_val);
      else push_request(plan[k].req, plan[k].typed, plan[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 3);
      case (ph)
        0:       begin vbit = 1'b0; mask_pick = 16'h0000; end
        1:       begin vbit = 1'b1; mask_pick = 16'hFFFF; end
        2:       begin vbit = 1'b1; mask_pick = 16'h7FFE; end
        default: begin
          vbit      = $urandom_range(0, 1);
          mask_pick = $urandom_range(0, 16'hFFFF);
        end
      endcase
      write_reg(REG_VERSION_SELECT, {15'd0, vbit});
      write_reg(REG_PROTECTED_MASK, mask_pick);
      for (int n = 0; n < ((ph == 1) ? 30 : 150); n++)
        push_request(pick_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/dmarat_pkg.sv
hdl/dmarat_cell.sv
hdl/dma_region_allow_table_top.sv
hdl/dmarat_checker.sv
tb/tb_dma_region_allow_table_top.sv
